// ===== rtl/core/circle_triangle_overlap_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef CIRCLE_TRIANGLE_OVERLAP_DEFINES_SVH
`define CIRCLE_TRIANGLE_OVERLAP_DEFINES_SVH

`ifndef SYNTH
`define CTOV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CTOV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CTOV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CTOV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/ctov_pkg.sv =====
package ctov_pkg;

  localparam int NUM_STAGES = 6;

  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
    logic [NUM_STAGES-1:0] vld;
  } ctov_ctl_t;

endpackage

// ===== rtl/core/ctov_if.sv =====
interface ctov_req_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic        [COORD_WIDTH-2:0] radius;
  logic signed [COORD_WIDTH-1:0] vertex0_x;
  logic signed [COORD_WIDTH-1:0] vertex0_y;
  logic signed [COORD_WIDTH-1:0] vertex1_x;
  logic signed [COORD_WIDTH-1:0] vertex1_y;
  logic signed [COORD_WIDTH-1:0] vertex2_x;
  logic signed [COORD_WIDTH-1:0] vertex2_y;

  modport source (
    output valid, center_x, center_y, radius,
           vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, radius,
           vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
    output ready
  );
endinterface

interface ctov_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ===== rtl/core/ctov_ctrl.sv =====
`include "circle_triangle_overlap_defines.svh"

module ctov_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctov_pkg::ctov_ctl_t ctl_o
);

  localparam int NS = ctov_pkg::NUM_STAGES;

  logic [NS-1:0] vld_q, vld_d, ld;
  logic          run_q;
  logic          in_fire, out_fire;

  // a stage may load when empty or when its content moves on
  always_comb begin
    ld[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign in_ready_o  = ld[0] && run_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = vld_q[NS-1];
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    vld_d    = vld_q;
    vld_d[0] = ld[0] ? in_fire : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      if (ld[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      run_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      run_q <= 1'b1;
    end
  end

  assign ctl_o.ld  = ld;
  assign ctl_o.vld = vld_q;

  `CTOV_ASSERT_NXT(a_req_enters, clk_i, rst_ni, in_fire, vld_q[0])
  `CTOV_ASSERT_NXT(a_occupancy, clk_i, rst_ni, 1'b1, $countones(vld_q) == $past($countones(vld_q)) + int'($past(in_fire)) - int'($past(out_fire)))
  `CTOV_ASSERT_NXT(a_mid_hold, clk_i, rst_ni, vld_q[2] && !ld[2], vld_q[2])
  `CTOV_ASSERT_IMP(a_stall_back, clk_i, rst_ni, !ld[0], vld_q[NS-1] && !out_ready_i)

endmodule

// ===== rtl/core/ctov_geom.sv =====
module ctov_geom #(
  parameter int CW = 16
) (
  input  logic                clk_i,
  input  ctov_pkg::ctov_ctl_t ctl_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  input  logic        [CW-2:0] r_i,
  input  logic signed [CW-1:0] vx_i [3],
  input  logic signed [CW-1:0] vy_i [3],
  output logic [2*CW+1:0]      ac_o [3],
  output logic [2*CW+1:0]      len2_o [3],
  output logic [2*CW-3:0]      r2_o,
  output logic [2:0]           eg_o,
  output logic                 near_o,
  output logic                 inside_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int SW = 2 * CW + 3;
  localparam int LW = 2 * CW + 2;
  localparam int RW = 2 * CW - 2;

  // stage 1: differences
  logic signed [DW-1:0] ex_q [3], ey_q [3], dx_q [3], dy_q [3];
  logic        [CW-2:0] r_q;
  // stage 2: products
  logic signed [PW-1:0] mxd_q [3], myd_q [3], mxn_q [3], myn_q [3];
  logic signed [PW-1:0] mxx_q [3], myy_q [3], mdx_q [3], mdy_q [3];
  logic signed [PW-1:0] mc1_q [3], mc2_q [3];
  logic        [RW-1:0] r2_q;
  // stage 3: sums and flags
  logic signed [SW-1:0] dot0_c [3], dot1_c [3], cross_c [3], ncross_c [3];
  logic        [LW-1:0] len2_c [3], dist_c [3];
  logic        [2:0]    eg_c, close_c, pos_c;
  logic        [LW-1:0] ac_q [3], len2_q [3];
  logic        [RW-1:0] r2s_q;
  logic        [2:0]    eg_q;
  logic                 near_q, inside_q;

  for (genvar g = 0; g < 3; g++) begin : g_edge
    localparam int N = (g == 2) ? 0 : g + 1;

    always_ff @(posedge clk_i) begin
      if (ctl_i.ld[0]) begin
        ex_q[g] <= DW'(vx_i[N]) - DW'(vx_i[g]);
        ey_q[g] <= DW'(vy_i[N]) - DW'(vy_i[g]);
        dx_q[g] <= DW'(cx_i) - DW'(vx_i[g]);
        dy_q[g] <= DW'(cy_i) - DW'(vy_i[g]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.ld[1]) begin
        mxd_q[g] <= ex_q[g] * dx_q[g];
        myd_q[g] <= ey_q[g] * dy_q[g];
        mxn_q[g] <= ex_q[g] * dx_q[N];
        myn_q[g] <= ey_q[g] * dy_q[N];
        mxx_q[g] <= ex_q[g] * ex_q[g];
        myy_q[g] <= ey_q[g] * ey_q[g];
        mdx_q[g] <= dx_q[g] * dx_q[g];
        mdy_q[g] <= dy_q[g] * dy_q[g];
        mc1_q[g] <= ex_q[g] * dy_q[g];
        mc2_q[g] <= dx_q[g] * ey_q[g];
      end
    end

    assign dot0_c[g]   = SW'(mxd_q[g]) + SW'(myd_q[g]);
    assign dot1_c[g]   = SW'(mxn_q[g]) + SW'(myn_q[g]);
    assign cross_c[g]  = SW'(mc1_q[g]) - SW'(mc2_q[g]);
    assign ncross_c[g] = -cross_c[g];
    assign len2_c[g]   = $unsigned(mxx_q[g]) + $unsigned(myy_q[g]);
    assign dist_c[g]   = $unsigned(mdx_q[g]) + $unsigned(mdy_q[g]);
    assign eg_c[g]     = !dot0_c[g][SW-1] && (dot1_c[g][SW-1] || dot1_c[g] == '0)
                         && len2_c[g] != '0;
    assign close_c[g]  = dist_c[g] <= LW'(r2_q);
    assign pos_c[g]    = !cross_c[g][SW-1] && cross_c[g] != '0;

    always_ff @(posedge clk_i) begin
      if (ctl_i.ld[2]) begin
        ac_q[g]   <= cross_c[g][SW-1] ? ncross_c[g][LW-1:0] : cross_c[g][LW-1:0];
        len2_q[g] <= len2_c[g];
      end
    end

    assign ac_o[g]   = ac_q[g];
    assign len2_o[g] = len2_q[g];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[0]) begin
      r_q <= r_i;
    end
    if (ctl_i.ld[1]) begin
      r2_q <= RW'(r_q) * RW'(r_q);
    end
    if (ctl_i.ld[2]) begin
      r2s_q    <= r2_q;
      eg_q     <= eg_c;
      near_q   <= |close_c;
      inside_q <= &pos_c;
    end
  end

  assign r2_o     = r2s_q;
  assign eg_o     = eg_q;
  assign near_o   = near_q;
  assign inside_o = inside_q;

endmodule

// ===== rtl/core/ctov_dist.sv =====
module ctov_dist #(
  parameter int CW = 16
) (
  input  logic                clk_i,
  input  ctov_pkg::ctov_ctl_t ctl_i,
  input  logic [2*CW+1:0]     ac_i [3],
  input  logic [2*CW+1:0]     len2_i [3],
  input  logic [2*CW-3:0]     r2_i,
  input  logic [2:0]          eg_i,
  input  logic                near_i,
  input  logic                inside_i,
  output logic                hit_o
);

  localparam int H   = CW + 1;
  localparam int RW  = 2 * CW - 2;
  localparam int RHW = RW - H;
  localparam int FW  = 4 * H;

  // stage 4: partial products, stage 5: full products, stage 6: compare
  logic [2*H-1:0]     aa_hh_q [3], aa_hl_q [3], aa_ll_q [3];
  logic [RHW+H-1:0]   rl_hh_q [3], rl_hl_q [3];
  logic [2*H-1:0]     rl_lh_q [3], rl_ll_q [3];
  logic [FW-1:0]      sq_q [3], prod_q [3];
  logic [2:0]         le_c;
  logic [2:0]         eg4_q, eg5_q;
  logic               near4_q, near5_q, inside4_q, inside5_q;
  logic               hit_q;

  for (genvar g = 0; g < 3; g++) begin : g_edge
    logic [H-1:0]   ah, al, lh, ll;
    logic [RHW-1:0] rh;
    logic [H-1:0]   rl;

    assign ah = ac_i[g][2*H-1:H];
    assign al = ac_i[g][H-1:0];
    assign lh = len2_i[g][2*H-1:H];
    assign ll = len2_i[g][H-1:0];
    assign rh = r2_i[RW-1:H];
    assign rl = r2_i[H-1:0];

    always_ff @(posedge clk_i) begin
      if (ctl_i.ld[3]) begin
        aa_hh_q[g] <= ah * ah;
        aa_hl_q[g] <= ah * al;
        aa_ll_q[g] <= al * al;
        rl_hh_q[g] <= rh * lh;
        rl_hl_q[g] <= rh * ll;
        rl_lh_q[g] <= rl * lh;
        rl_ll_q[g] <= rl * ll;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.ld[4]) begin
        sq_q[g]   <= {aa_hh_q[g], aa_ll_q[g]} + (FW'(aa_hl_q[g]) << (H + 1));
        prod_q[g] <= (FW'(rl_hh_q[g]) << (2 * H)) + (FW'(rl_hl_q[g]) << H)
                     + (FW'(rl_lh_q[g]) << H) + FW'(rl_ll_q[g]);
      end
    end

    assign le_c[g] = sq_q[g] <= prod_q[g];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[3]) begin
      eg4_q     <= eg_i;
      near4_q   <= near_i;
      inside4_q <= inside_i;
    end
    if (ctl_i.ld[4]) begin
      eg5_q     <= eg4_q;
      near5_q   <= near4_q;
      inside5_q <= inside4_q;
    end
    if (ctl_i.ld[5]) begin
      hit_q <= (|(eg5_q & le_c)) || near5_q || inside5_q;
    end
  end

  assign hit_o = hit_q;

endmodule

// ===== rtl/core/circle_triangle_overlap.sv =====
// Channel   Dir  Payload                                   Handshake
// req_i     in   center_x/y, radius, vertex0..2_x/y        valid/ready
// rsp_o     out  hit                                       valid/ready
//
// One request per cycle unless a stall on rsp_o backs up to the first stage;
// the hit result passes through six register stages (differences, products,
// sums, partial products, full products, compare), the first of which loads at the accepting edge.
// Reset clears the stage valid bits; ready stays low until the first edge
// after reset is released.
// A stall on rsp_o holds the filled stages in place; empty stages keep filling.
module circle_triangle_overlap #(
  parameter int COORD_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ctov_req_if.sink         req_i,
  ctov_rsp_if.source       rsp_o
);

  localparam int CW = COORD_WIDTH;

  ctov_pkg::ctov_ctl_t   ctl;
  logic signed [CW-1:0]  vx [3], vy [3];
  logic [2*CW+1:0]       ac [3], len2 [3];
  logic [2*CW-3:0]       r2;
  logic [2:0]            eg;
  logic                  near, in_tri;

  assign vx[0] = req_i.vertex0_x;
  assign vy[0] = req_i.vertex0_y;
  assign vx[1] = req_i.vertex1_x;
  assign vy[1] = req_i.vertex1_y;
  assign vx[2] = req_i.vertex2_x;
  assign vy[2] = req_i.vertex2_y;

  ctov_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctl_o       (ctl)
  );

  ctov_geom #(.CW(CW)) u_geom (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .cx_i     (req_i.center_x),
    .cy_i     (req_i.center_y),
    .r_i      (req_i.radius),
    .vx_i     (vx),
    .vy_i     (vy),
    .ac_o     (ac),
    .len2_o   (len2),
    .r2_o     (r2),
    .eg_o     (eg),
    .near_o   (near),
    .inside_o (in_tri)
  );

  ctov_dist #(.CW(CW)) u_dist (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .ac_i     (ac),
    .len2_i   (len2),
    .r2_i     (r2),
    .eg_i     (eg),
    .near_i   (near),
    .inside_i (in_tri),
    .hit_o    (rsp_o.hit)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CW = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int CHUNKS = 8;
  localparam int CHUNK_ITEMS = 204;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [CW-2:0] r;
    logic signed [CW-1:0] vx[3];
    logic signed [CW-1:0] vy[3];
  } circle_tri_t;

  class overlap_book;
    bit hits_due[$];
    int errors;

    function bit predict_overlap(circle_tri_t q);
      longint cx, cy, r2;
      longint vx[3], vy[3], ex[3], ey[3], dx[3], dy[3];
      longint dot0, dot1, len2, d0, d1, cr;
      logic [127:0] lhs, rhs;
      bit hit, in_tri;
      int n;
      cx = q.cx;
      cy = q.cy;
      r2 = longint'(q.r) * longint'(q.r);
      for (int i = 0; i < 3; i++) begin
        vx[i] = q.vx[i];
        vy[i] = q.vy[i];
      end
      for (int i = 0; i < 3; i++) begin
        n = (i == 2) ? 0 : i + 1;
        ex[i] = vx[n] - vx[i];
        ey[i] = vy[n] - vy[i];
        dx[i] = cx - vx[i];
        dy[i] = cy - vy[i];
      end
      hit = 1'b0;
      for (int i = 0; i < 3 && !hit; i++) begin
        n = (i == 2) ? 0 : i + 1;
        dot0 = ex[i] * dx[i] + ey[i] * dy[i];
        dot1 = ex[i] * dx[n] + ey[i] * dy[n];
        len2 = ex[i] * ex[i] + ey[i] * ey[i];
        d0 = dx[i] * dx[i] + dy[i] * dy[i];
        d1 = dx[n] * dx[n] + dy[n] * dy[n];
        if (dot0 >= 0 && dot1 <= 0 && len2 != 0) begin
          cr = ex[i] * dy[i] - dx[i] * ey[i];
          if (cr < 0) cr = -cr;
          lhs = cr;
          lhs = lhs * lhs;
          rhs = r2;
          rhs = rhs * len2;
          if (lhs <= rhs) hit = 1'b1;
        end
        if (d0 <= r2 || d1 <= r2) hit = 1'b1;
      end
      if (!hit) begin
        in_tri = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (ex[i] * dy[i] - dx[i] * ey[i] <= 0) in_tri = 1'b0;
        end
        hit = in_tri;
      end
      return hit;
    endfunction

    function void note(circle_tri_t q);
      hits_due.push_back(predict_overlap(q));
    endfunction

    function void check(logic hit);
      bit want;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected hit result, expected none, actual %b", $time, hit);
        errors++;
      end else begin
        want = hits_due.pop_front();
        if (hit !== want) begin
          $display("%0t: hit mismatch, expected %b, actual %b", $time, want, hit);
          errors++;
        end
      end
    endfunction

    function int pending();
      return hits_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycle_cnt = 0;

  bit req_lazy;
  bit rsp_lazy;
  bit hold_pending;

  overlap_book book = new();

  ctov_req_if #(.COORD_WIDTH(CW)) req_if ();
  ctov_rsp_if rsp_if ();

  circle_triangle_overlap #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic circle_tri_t pack_req(int cx, int cy, int r, int x0, int y0,
                                           int x1, int y1, int x2, int y2);
    circle_tri_t q;
    q.cx = cx[CW-1:0];
    q.cy = cy[CW-1:0];
    q.r = r[CW-2:0];
    q.vx[0] = x0[CW-1:0];
    q.vy[0] = y0[CW-1:0];
    q.vx[1] = x1[CW-1:0];
    q.vy[1] = y1[CW-1:0];
    q.vx[2] = x2[CW-1:0];
    q.vy[2] = y2[CW-1:0];
    return q;
  endfunction

  function automatic int near(int base, int span);
    return base + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic circle_tri_t random_req();
    int kind, span, bx, by, j, a, b, c, m, t;
    int x[3], y[3];
    circle_tri_t q;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0: span = 8;
      1: span = 200;
      2: span = 3000;
      default: span = 20000;
    endcase
    bx = int'($urandom_range(0, 65535)) - 32768;
    by = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < 3; i++) begin
      x[i] = near(bx, span);
      y[i] = near(by, span);
    end
    case (kind)
      0, 1: begin
        q = pack_req($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
      end
      6: begin
        a = near(0, span);
        b = near(0, span);
        t = $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1)) begin
          x[1] = x[0];
          y[1] = y[0];
        end else begin
          x[1] = x[0] + a;
          y[1] = y[0] + b;
        end
        x[2] = x[0] + t * a;
        y[2] = y[0] + t * b;
        q = pack_req(near(x[0], span), near(y[0], span), $urandom_range(0, span),
                     x[0], y[0], x[1], y[1], x[2], y[2]);
      end
      7, 8: begin
        case ($urandom_range(0, 3))
          0: begin a = 3; b = 4; c = 5; end
          1: begin a = 5; b = 12; c = 13; end
          2: begin a = 8; b = 15; c = 17; end
          default: begin a = 7; b = 24; c = 25; end
        endcase
        m = $urandom_range(1, 100);
        a = a * m;
        b = b * m;
        if ($urandom_range(0, 1)) begin t = a; a = b; b = t; end
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
        j = $urandom_range(0, 2);
        q = pack_req(x[j] + a, y[j] + b, c * m - int'($urandom_range(0, 1)),
                     x[0], y[0], x[1], y[1], x[2], y[2]);
      end
      9: begin
        j = $urandom_range(0, 2);
        m = (j == 2) ? 0 : j + 1;
        t = $urandom_range(0, 4);
        q = pack_req(x[j] + (x[m] - x[j]) * t / 4 + near(0, 2),
                     y[j] + (y[m] - y[j]) * t / 4 + near(0, 2), $urandom_range(0, 3),
                     x[0], y[0], x[1], y[1], x[2], y[2]);
      end
      default: begin
        q = pack_req(near(bx, span + span / 2), near(by, span + span / 2),
                     $urandom_range(0, span), x[0], y[0], x[1], y[1], x[2], y[2]);
      end
    endcase
    return q;
  endfunction

  task automatic send_req(circle_tri_t q);
    int gap;
    req_if.valid <= 1'b1;
    req_if.center_x <= q.cx;
    req_if.center_y <= q.cy;
    req_if.radius <= q.r;
    req_if.vertex0_x <= q.vx[0];
    req_if.vertex0_y <= q.vy[0];
    req_if.vertex1_x <= q.vx[1];
    req_if.vertex1_y <= q.vy[1];
    req_if.vertex2_x <= q.vx[2];
    req_if.vertex2_y <= q.vy[2];
    do @(posedge clk); while (!req_if.ready);
    book.note(q);
    gap = req_lazy ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // response side: random stalls plus one long hold-off on request
  initial begin
    int gap, hold;
    gap = 0;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) book.check(rsp_if.hit);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (rsp_lazy && $urandom_range(0, 3) == 0) gap = pick_gap();
      end
    end
  end

  initial begin
    circle_tri_t directed[$];
    req_lazy = 1'b1;
    rsp_lazy = 1'b1;
    hold_pending = 1'b0;
    req_if.valid <= 1'b0;
    req_if.center_x <= '0;
    req_if.center_y <= '0;
    req_if.radius <= '0;
    req_if.vertex0_x <= '0;
    req_if.vertex0_y <= '0;
    req_if.vertex1_x <= '0;
    req_if.vertex1_y <= '0;
    req_if.vertex2_x <= '0;
    req_if.vertex2_y <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(pack_req(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767));
    directed.push_back(pack_req(-32768, -32768, 0, -32768, -32768, -32768, -32768,
                                -32768, -32768));
    directed.push_back(pack_req(0, 0, 0, -32768, -32768, 32767, -32768, 0, 32767));
    directed.push_back(pack_req(0, 0, 0, -32768, -32768, 0, 32767, 32767, -32768));
    directed.push_back(pack_req(-32768, 32767, 32767, 32767, -32768, 32767, -32767,
                                32766, -32768));
    // inside test, both windings
    directed.push_back(pack_req(10, 10, 0, 0, 0, 100, 0, 0, 100));
    directed.push_back(pack_req(10, 10, 0, 0, 0, 0, 100, 100, 0));
    // edge distance, on and around the boundary
    directed.push_back(pack_req(50, 0, 0, 0, 0, 100, 0, 0, 100));
    directed.push_back(pack_req(50, -5, 5, 0, 0, 100, 0, 0, 100));
    directed.push_back(pack_req(50, -5, 4, 0, 0, 100, 0, 0, 100));
    // vertex distance
    directed.push_back(pack_req(-3, -4, 5, 0, 0, 100, 0, 0, 100));
    directed.push_back(pack_req(-3, -4, 4, 0, 0, 100, 0, 0, 100));
    directed.push_back(pack_req(100, -3, 3, 0, 0, 100, 0, 0, 100));
    directed.push_back(pack_req(150, -1, 1, 0, 0, 100, 0, 0, 100));
    // zero-length edge
    directed.push_back(pack_req(50, 40, 3, 0, 0, 0, 0, 100, 100));
    directed.push_back(pack_req(50, 40, 8, 0, 0, 0, 0, 100, 100));
    directed.push_back(pack_req(0, 0, 0, 0, 0, 0, 0, 100, 100));
    // collinear and single-point triangles
    directed.push_back(pack_req(50, 52, 1, 0, 0, 50, 50, 100, 100));
    directed.push_back(pack_req(50, 52, 2, 0, 0, 50, 50, 100, 100));
    directed.push_back(pack_req(5, 5, 2, 7, 7, 7, 7, 7, 7));
    directed.push_back(pack_req(5, 5, 3, 7, 7, 7, 7, 7, 7));
    foreach (directed[i]) send_req(directed[i]);

    for (int k = 0; k < CHUNKS; k++) begin
      req_lazy = k[0];
      rsp_lazy = k[1];
      if (k == 2) begin
        req_lazy = 1'b0;
        hold_pending = 1'b1;
      end
      for (int i = 0; i < CHUNK_ITEMS; i++) send_req(random_req());
    end
    req_if.valid <= 1'b0;
    rsp_lazy = 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
